### hw/rtl/actuator_position_supervisor_assert.svh
// Assertion macros for the actuator position supervisor
`ifndef ACTUATOR_POSITION_SUPERVISOR_ASSERT_SVH
`define ACTUATOR_POSITION_SUPERVISOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define APS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("actuator supervisor check failed");

// next-cycle implication, disabled in reset
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("actuator supervisor check failed");

`endif

### hw/rtl/aps_pkg.sv
// Package: types, codes and constants of the actuator position supervisor
package aps_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CFG_ADDR_BITS      = 5;
  localparam int CFG_DATA_BITS      = 32;
  localparam int CFG_REG_BITS       = 16;
  localparam int MODE_BITS          = 6;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RETRY  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_SETTLE = 3'd3
  } phase_t;

  typedef enum logic [2:0] {
    CMD_EXTEND_STEP  = 3'd0,
    CMD_RETRACT_STEP = 3'd1,
    CMD_EXTEND_NOW   = 3'd2,
    CMD_RETRACT_NOW  = 3'd3,
    CMD_RESET_PHASES = 3'd4,
    CMD_POLL         = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SET_EXT = 3'd1,
    EV_CLR_EXT = 3'd2,
    EV_SET_RET = 3'd3,
    EV_CLR_RET = 3'd4
  } alarm_event_t;

  typedef enum logic [2:0] {
    REG_MODE           = 3'd0,
    REG_EXTEND_TIMEOUT = 3'd1,
    REG_RETRACT_TIMEOUT = 3'd2,
    REG_EXTEND_SETTLE  = 3'd3,
    REG_RETRACT_SETTLE = 3'd4
  } reg_idx_t;

  localparam int MODE_ENABLED  = 0;
  localparam int MODE_EXT_FIT  = 1;
  localparam int MODE_RET_FIT  = 2;
  localparam int MODE_EXT_LOW  = 3;
  localparam int MODE_RET_LOW  = 4;
  localparam int MODE_INVERT   = 5;

  typedef struct packed {
    logic [MODE_BITS-1:0]    mode;
    logic [CFG_REG_BITS-1:0] ext_tmo;
    logic [CFG_REG_BITS-1:0] ret_tmo;
    logic [CFG_REG_BITS-1:0] ext_settle;
    logic [CFG_REG_BITS-1:0] ret_settle;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic is_extend;
    logic fitted;
    logic sensed;
    logic running;
    logic paused;
  } side_ctrl_t;

  typedef struct packed {
    logic         done;
    logic         pos_we;
    logic         pos_val;
    alarm_event_t ev;
  } side_stat_t;

endpackage

### hw/rtl/aps_cfg.sv
// Configuration register file with APB-style access
module aps_cfg import aps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:            cfg.mode       <= pwdata[MODE_BITS-1:0];
        REG_EXTEND_TIMEOUT:  cfg.ext_tmo    <= pwdata[CFG_REG_BITS-1:0];
        REG_RETRACT_TIMEOUT: cfg.ret_tmo    <= pwdata[CFG_REG_BITS-1:0];
        REG_EXTEND_SETTLE:   cfg.ext_settle <= pwdata[CFG_REG_BITS-1:0];
        REG_RETRACT_SETTLE:  cfg.ret_settle <= pwdata[CFG_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:            prdata = CFG_DATA_BITS'(cfg.mode);
      REG_EXTEND_TIMEOUT:  prdata = CFG_DATA_BITS'(cfg.ext_tmo);
      REG_RETRACT_TIMEOUT: prdata = CFG_DATA_BITS'(cfg.ret_tmo);
      REG_EXTEND_SETTLE:   prdata = CFG_DATA_BITS'(cfg.ext_settle);
      REG_RETRACT_SETTLE:  prdata = CFG_DATA_BITS'(cfg.ret_settle);
      default:             prdata = '0;
    endcase
  end

endmodule

### hw/rtl/aps_side.sv
// Next-state logic of one actuator side: wait, settle, retry and alarm
module aps_side import aps_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  side_ctrl_t            ctrl,
  input  phase_t                phase,
  input  logic                  retry,
  input  logic [TIMER_BITS-1:0] wt,
  input  logic [TIMER_BITS-1:0] st,
  input  logic [TIMER_BITS-1:0] tmo,
  input  logic [TIMER_BITS-1:0] settle,
  output phase_t                phase_next,
  output logic                  retry_next,
  output logic [TIMER_BITS-1:0] wt_next,
  output logic [TIMER_BITS-1:0] st_next,
  output side_stat_t            stat
);

  always_comb begin
    logic go, fail, halt, finish;
    phase_next = phase;
    retry_next = retry;
    wt_next    = wt;
    st_next    = st;
    stat       = '{done: 1'b0, pos_we: 1'b0, pos_val: 1'b0, ev: EV_NONE};
    go     = 1'b0;
    fail   = 1'b0;
    halt   = 1'b0;
    finish = 1'b0;
    if (ctrl.active) begin
      if (phase_next == PH_IDLE || phase_next == PH_RETRY) begin
        if (!ctrl.fitted || ctrl.sensed) begin
          go = 1'b1;
        end else if (tmo == '0) begin
          fail = 1'b1;
        end else begin
          wt_next    = tmo;
          phase_next = PH_WAIT;
        end
      end
      if (!go && !fail && phase_next == PH_WAIT) begin
        if (ctrl.sensed) begin
          go = 1'b1;
        end else begin
          halt = 1'b1;
          if (ctrl.paused) begin
            wt_next = tmo;
          end else if (wt_next == '0) begin
            fail = 1'b1;
          end
        end
      end
      if (go) begin
        if (settle == '0) begin
          finish = 1'b1;
        end else begin
          st_next    = settle;
          phase_next = PH_SETTLE;
        end
      end
      if (!fail && !halt && !finish && phase_next == PH_SETTLE && st_next == '0) begin
        finish = 1'b1;
      end
      if (fail) begin
        phase_next   = PH_IDLE;
        stat.pos_we  = 1'b1;
        stat.pos_val = !ctrl.is_extend;
        if (ctrl.running) begin
          if (retry) begin
            stat.ev    = ctrl.is_extend ? EV_SET_EXT : EV_SET_RET;
            retry_next = 1'b0;
          end else begin
            retry_next = 1'b1;
            phase_next = PH_RETRY;
          end
        end
      end
      if (finish) begin
        phase_next   = PH_IDLE;
        retry_next   = 1'b0;
        stat.done    = 1'b1;
        stat.pos_we  = 1'b1;
        stat.pos_val = ctrl.is_extend;
        stat.ev      = ctrl.is_extend ? EV_CLR_EXT : EV_CLR_RET;
      end
    end
  end

endmodule

### hw/rtl/actuator_position_supervisor.sv
// Top level of the actuator position supervisor
//
//   channel  | handshake             | words
//   ---------+-----------------------+-------------------------------------------
//   in       | in_valid / in_stall   | cmd, sensor levels, run, pause, tick
//   out      | out_valid / out_stall | done, position, drive, alarm, finished, at_*
//   config   | APB psel/penable      | mode, timeouts, settle delays
//
// One word per cycle unless the output stalls; an accepted word waits in the input register,
// and its result then appears on the output from the result register. The supervisor state
// updates as a word moves from the input register into the result register.
// A stalled output holds the result register and backs up into the input register.
// Reset (rst, synchronous) idles both phases and clears timers and latches.
module actuator_position_supervisor import aps_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               cmd,
  input  logic                     extend_sensor_raw,
  input  logic                     retract_sensor_raw,
  input  logic                     machine_running,
  input  logic                     handler_paused,
  input  logic                     tick,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     step_done,
  output logic                     position_status,
  output logic                     drive_level,
  output logic [2:0]               alarm_event,
  output logic                     motion_finished,
  output logic                     at_extended,
  output logic                     at_retracted
);

  `include "actuator_position_supervisor_assert.svh"

  cfg_t cfg;

  aps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic       in_full;
  cmd_t       cmd_r;
  logic       ext_raw_r, ret_raw_r, running_r, paused_r, tick_r;
  logic       move;

  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r     <= cmd_t'(cmd);
      ext_raw_r <= extend_sensor_raw;
      ret_raw_r <= retract_sensor_raw;
      running_r <= machine_running;
      paused_r  <= handler_paused;
      tick_r    <= tick;
    end
  end

  phase_t                ext_phase, ret_phase;
  logic                  ext_retry, ret_retry;
  logic [TIMER_BITS-1:0] ext_wt, ret_wt, ext_st, ret_st;
  logic                  believed, latch;

  logic [TIMER_BITS-1:0] ext_wt_dec, ret_wt_dec, ext_st_dec, ret_st_dec;
  logic [TIMER_BITS+CFG_REG_BITS-1:0] ext_tmo_w, ret_tmo_w, ext_set_w, ret_set_w;
  logic [TIMER_BITS-1:0] ext_tmo, ret_tmo, ext_set, ret_set;

  assign ext_wt_dec = (tick_r && ext_wt != '0) ? ext_wt - 1'b1 : ext_wt;
  assign ret_wt_dec = (tick_r && ret_wt != '0) ? ret_wt - 1'b1 : ret_wt;
  assign ext_st_dec = (tick_r && ext_st != '0) ? ext_st - 1'b1 : ext_st;
  assign ret_st_dec = (tick_r && ret_st != '0) ? ret_st - 1'b1 : ret_st;

  assign ext_tmo_w = {{TIMER_BITS{1'b0}}, cfg.ext_tmo};
  assign ret_tmo_w = {{TIMER_BITS{1'b0}}, cfg.ret_tmo};
  assign ext_set_w = {{TIMER_BITS{1'b0}}, cfg.ext_settle};
  assign ret_set_w = {{TIMER_BITS{1'b0}}, cfg.ret_settle};
  assign ext_tmo   = ext_tmo_w[TIMER_BITS-1:0];
  assign ret_tmo   = ret_tmo_w[TIMER_BITS-1:0];
  assign ext_set   = ext_set_w[TIMER_BITS-1:0];
  assign ret_set   = ret_set_w[TIMER_BITS-1:0];

  logic enabled, ext_fit, ret_fit, inv, ext_on, ret_on, at_ext, at_ret;

  assign enabled = cfg.mode[MODE_ENABLED];
  assign ext_fit = cfg.mode[MODE_EXT_FIT];
  assign ret_fit = cfg.mode[MODE_RET_FIT];
  assign inv     = cfg.mode[MODE_INVERT];
  assign ext_on  = ext_fit && (ext_raw_r != cfg.mode[MODE_EXT_LOW]);
  assign ret_on  = ret_fit && (ret_raw_r != cfg.mode[MODE_RET_LOW]);

  always_comb begin
    if (!enabled)     at_ext = 1'b1;
    else if (ext_fit) at_ext = ext_on;
    else if (ret_fit) at_ext = !ret_on;
    else              at_ext = 1'b1;
    if (!enabled)     at_ret = 1'b1;
    else if (ret_fit) at_ret = ret_on;
    else if (ext_fit) at_ret = !ext_on;
    else              at_ret = 1'b1;
  end

  side_ctrl_t            ext_ctrl, ret_ctrl;
  side_stat_t            ext_stat, ret_stat;
  phase_t                ext_phase_s, ret_phase_s;
  logic                  ext_retry_s, ret_retry_s;
  logic [TIMER_BITS-1:0] ext_wt_s, ret_wt_s, ext_st_s, ret_st_s;

  assign ext_ctrl = '{active: cmd_r == CMD_EXTEND_STEP, is_extend: 1'b1, fitted: ext_fit,
                      sensed: ext_on, running: running_r, paused: paused_r};
  assign ret_ctrl = '{active: cmd_r == CMD_RETRACT_STEP, is_extend: 1'b0, fitted: ret_fit,
                      sensed: ret_on, running: running_r, paused: paused_r};

  aps_side #(.TIMER_BITS(TIMER_BITS)) u_ext (
    .ctrl       (ext_ctrl),
    .phase      (ext_phase),
    .retry      (ext_retry),
    .wt         (ext_wt_dec),
    .st         (ext_st_dec),
    .tmo        (ext_tmo),
    .settle     (ext_set),
    .phase_next (ext_phase_s),
    .retry_next (ext_retry_s),
    .wt_next    (ext_wt_s),
    .st_next    (ext_st_s),
    .stat       (ext_stat)
  );

  aps_side #(.TIMER_BITS(TIMER_BITS)) u_ret (
    .ctrl       (ret_ctrl),
    .phase      (ret_phase),
    .retry      (ret_retry),
    .wt         (ret_wt_dec),
    .st         (ret_st_dec),
    .tmo        (ret_tmo),
    .settle     (ret_set),
    .phase_next (ret_phase_s),
    .retry_next (ret_retry_s),
    .wt_next    (ret_wt_s),
    .st_next    (ret_st_s),
    .stat       (ret_stat)
  );

  phase_t       ext_phase_next, ret_phase_next;
  logic         ext_retry_next, ret_retry_next;
  logic         believed_next, latch_next, done_next;
  alarm_event_t ev_next;

  always_comb begin
    ext_phase_next = ext_phase_s;
    ret_phase_next = ret_phase_s;
    ext_retry_next = ext_retry_s;
    ret_retry_next = ret_retry_s;
    believed_next  = believed;
    latch_next     = latch;
    done_next      = 1'b0;
    ev_next        = EV_NONE;
    case (cmd_r)
      CMD_EXTEND_STEP: begin
        if (enabled) latch_next = !inv;
        if (ext_stat.pos_we) believed_next = ext_stat.pos_val;
        done_next = ext_stat.done;
        ev_next   = ext_stat.ev;
      end
      CMD_RETRACT_STEP: begin
        if (enabled) latch_next = inv;
        if (ret_stat.pos_we) believed_next = ret_stat.pos_val;
        done_next = ret_stat.done;
        ev_next   = ret_stat.ev;
      end
      CMD_EXTEND_NOW: begin
        believed_next  = 1'b1;
        ext_phase_next = PH_IDLE;
        if (enabled) latch_next = !inv;
      end
      CMD_RETRACT_NOW: begin
        believed_next  = 1'b0;
        ret_phase_next = PH_IDLE;
        if (enabled) latch_next = inv;
      end
      CMD_RESET_PHASES: begin
        ext_phase_next = PH_IDLE;
        ret_phase_next = PH_IDLE;
        ext_retry_next = 1'b0;
        ret_retry_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_phase <= PH_IDLE;
      ret_phase <= PH_IDLE;
      ext_retry <= 1'b0;
      ret_retry <= 1'b0;
      ext_wt    <= '0;
      ret_wt    <= '0;
      ext_st    <= '0;
      ret_st    <= '0;
      believed  <= 1'b0;
      latch     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        ext_phase <= ext_phase_next;
        ret_phase <= ret_phase_next;
        ext_retry <= ext_retry_next;
        ret_retry <= ret_retry_next;
        ext_wt    <= ext_wt_s;
        ret_wt    <= ret_wt_s;
        ext_st    <= ext_st_s;
        ret_st    <= ret_st_s;
        believed  <= believed_next;
        latch     <= latch_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      step_done       <= done_next;
      position_status <= believed_next;
      drive_level     <= latch_next;
      alarm_event     <= ev_next;
      motion_finished <= (ext_phase_next == PH_IDLE) && (ret_phase_next == PH_IDLE);
      at_extended     <= at_ext;
      at_retracted    <= at_ret;
    end
  end

  `APS_ASSERT_NOW(a_done_clears_alarm, clk, rst, out_valid && step_done,
    alarm_event == EV_CLR_EXT || alarm_event == EV_CLR_RET)
  `APS_ASSERT_NEXT(a_extend_now_pos, clk, rst, move && cmd_r == CMD_EXTEND_NOW,
    out_valid && position_status && !step_done)
  `APS_ASSERT_NEXT(a_reset_phases_idle, clk, rst, move && cmd_r == CMD_RESET_PHASES,
    out_valid && motion_finished && ext_phase == PH_IDLE && ret_phase == PH_IDLE)
  `APS_ASSERT_NEXT(a_input_held, clk, rst, in_full && !move, in_full)

endmodule
